>>> rtl/sks_pkg.sv
// Shared types, constants and character helpers for the SQL keyword scanner.
package sks_pkg;

   localparam int unsigned KwLen  = 9;
   localparam int unsigned LenSat = 10;

   localparam logic [3:0] KW_LEN_C  = 4'(KwLen);
   localparam logic [3:0] LEN_SAT_C = 4'(LenSat);
   localparam logic [1:0] MATCH_ALL = 2'b11;

   localparam logic [7:0] CH_DASH    = 8'h2D;
   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_STAR    = 8'h2A;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_SQUOTE  = 8'h27;
   localparam logic [7:0] CH_DQUOTE  = 8'h22;
   localparam logic [7:0] CH_UNDER   = 8'h5F;

   typedef enum logic [3:0] {
      MODE_NORMAL = 4'd0,
      MODE_IDENT  = 4'd1,
      MODE_DASH   = 4'd2,
      MODE_SLASH  = 4'd3,
      MODE_LINE   = 4'd4,
      MODE_BLOCK  = 4'd5,
      MODE_BSTAR  = 4'd6,
      MODE_SQ     = 4'd7,
      MODE_SQ_END = 4'd8,
      MODE_DQ     = 4'd9,
      MODE_DQ_END = 4'd10
   } mode_type;

   // Result of one query as handed from the scan core to the output register.
   typedef struct packed {
      logic done;
      logic found;
   } result_type;

   function automatic logic is_ident(input logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
             (c >= 8'h61 && c <= 8'h7A) || (c == CH_UNDER);
   endfunction

   function automatic logic [7:0] to_upper(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7A) ? (c - 8'h20) : c;
   endfunction

   // Spelling with S at position seven.
   function automatic logic [7:0] kw_s_char(input logic [3:0] idx);
      logic [7:0] r;
      case (idx)
         4'd0: r = 8'h56;
         4'd1: r = 8'h49;
         4'd2: r = 8'h53;
         4'd3: r = 8'h55;
         4'd4: r = 8'h41;
         4'd5: r = 8'h4C;
         4'd6: r = 8'h49;
         4'd7: r = 8'h53;
         4'd8: r = 8'h45;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   // Spelling with Z at position seven.
   function automatic logic [7:0] kw_z_char(input logic [3:0] idx);
      logic [7:0] r;
      r = kw_s_char(idx);
      if (idx == 4'd7) begin
         r = 8'h5A;
      end
      return r;
   endfunction

endpackage

>>> rtl/sks_scan_core.sv
// Scanner state registers and the per-byte next-state logic.
module sks_scan_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                step_valid,
   input  logic [7:0]          char_byte,
   input  logic                last_byte,
   output sks_pkg::result_type result
);
   import sks_pkg::*;

   mode_type   mode_ff, mode_in;
   logic [3:0] len_ff, len_in;
   logic [1:0] match_ff, match_in;
   logic       found_ff, found_in;

   always_comb begin
      logic       ident;
      logic       end_tok;
      logic       norm;
      logic       add;
      logic [7:0] up;
      logic [3:0] base_len;
      logic [1:0] base_match;
      logic       found_mid;
      mode_type   mode_mid;
      logic [3:0] len_mid;
      logic [1:0] match_mid;

      ident      = is_ident(char_byte);
      up         = to_upper(char_byte);
      end_tok    = 1'b0;
      norm       = 1'b0;
      add        = 1'b0;
      mode_mid   = mode_ff;
      case (mode_ff)
         MODE_IDENT: begin
            if (ident) begin
               add = 1'b1;
            end else begin
               end_tok = 1'b1;
               norm    = 1'b1;
            end
         end
         MODE_DASH:   if (char_byte == CH_DASH) mode_mid = MODE_LINE; else norm = 1'b1;
         MODE_SLASH:  if (char_byte == CH_STAR) mode_mid = MODE_BLOCK; else norm = 1'b1;
         MODE_LINE:   if (char_byte == CH_NEWLINE) mode_mid = MODE_NORMAL;
         MODE_BLOCK:  if (char_byte == CH_STAR) mode_mid = MODE_BSTAR;
         MODE_BSTAR: begin
            if (char_byte == CH_SLASH) begin
               mode_mid = MODE_NORMAL;
            end else if (char_byte != CH_STAR) begin
               mode_mid = MODE_BLOCK;
            end
         end
         MODE_SQ:     if (char_byte == CH_SQUOTE) mode_mid = MODE_SQ_END;
         MODE_SQ_END: if (char_byte == CH_SQUOTE) mode_mid = MODE_SQ; else norm = 1'b1;
         MODE_DQ:     if (char_byte == CH_DQUOTE) mode_mid = MODE_DQ_END;
         MODE_DQ_END: if (char_byte == CH_DQUOTE) mode_mid = MODE_DQ; else norm = 1'b1;
         default:     norm = 1'b1;
      endcase

      // Closing a token checks it against the keyword before it is cleared.
      found_mid = found_ff;
      if (end_tok && len_ff == KW_LEN_C && match_ff != 2'b00) begin
         found_mid = 1'b1;
      end

      if (norm) begin
         if (ident) begin
            add      = 1'b1;
            mode_mid = MODE_IDENT;
         end else if (char_byte == CH_DASH) begin
            mode_mid = MODE_DASH;
         end else if (char_byte == CH_SLASH) begin
            mode_mid = MODE_SLASH;
         end else if (char_byte == CH_SQUOTE) begin
            mode_mid = MODE_SQ;
         end else if (char_byte == CH_DQUOTE) begin
            mode_mid = MODE_DQ;
         end else begin
            mode_mid = MODE_NORMAL;
         end
      end

      // A token restarted from normal text begins at length zero.
      base_len   = (norm || end_tok) ? 4'd0 : len_ff;
      base_match = (norm || end_tok) ? MATCH_ALL : match_ff;
      len_mid    = base_len;
      match_mid  = base_match;
      if (add) begin
         if (base_len < KW_LEN_C) begin
            if (up != kw_s_char(base_len)) match_mid[0] = 1'b0;
            if (up != kw_z_char(base_len)) match_mid[1] = 1'b0;
         end else begin
            match_mid = 2'b00;
         end
         if (base_len < LEN_SAT_C) begin
            len_mid = base_len + 4'd1;
         end
      end

      result.done  = step_valid && last_byte;
      result.found = found_mid ||
                     (mode_mid == MODE_IDENT && len_mid == KW_LEN_C && match_mid != 2'b00);

      mode_in  = mode_ff;
      len_in   = len_ff;
      match_in = match_ff;
      found_in = found_ff;
      if (step_valid) begin
         if (last_byte) begin
            mode_in  = MODE_NORMAL;
            len_in   = 4'd0;
            match_in = MATCH_ALL;
            found_in = 1'b0;
         end else begin
            mode_in  = mode_mid;
            len_in   = len_mid;
            match_in = match_mid;
            found_in = found_mid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_NORMAL;
         len_ff   <= 4'd0;
         match_ff <= MATCH_ALL;
         found_ff <= 1'b0;
      end else begin
         mode_ff  <= mode_in;
         len_ff   <= len_in;
         match_ff <= match_in;
         found_ff <= found_in;
      end
   end

   a_reset_after_last: assert property (@(posedge clock) disable iff (reset)
      (step_valid && last_byte) |=>
         (mode_ff == MODE_NORMAL && len_ff == 4'd0 && match_ff == MATCH_ALL && !found_ff))
      else $error("scanner state not cleared after last word");

   a_len_saturates: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LEN_SAT_C)
      else $error("token length beyond saturation");

   a_found_clears_only_at_end: assert property (@(posedge clock) disable iff (reset)
      $fell(found_ff) |-> $past(step_valid && last_byte))
      else $error("found flag lost inside a query");

endmodule

>>> rtl/sks_out_reg.sv
// Result register with valid/ready handshake toward the consumer.
module sks_out_reg (
   input  logic                clock,
   input  logic                reset,
   input  sks_pkg::result_type result,
   output logic                load_ok,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_keyword_found
);
   import sks_pkg::*;

   logic valid_ff, valid_in;
   logic found_ff, found_in;

   // The register can take a new result when empty or being drained.
   assign load_ok = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      found_in = found_ff;
      if (rsp_ready) begin
         valid_in = 1'b0;
      end
      if (result.done) begin
         valid_in = 1'b1;
         found_in = result.found;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      found_ff <= found_in;
   end

   assign rsp_valid         = valid_ff;
   assign rsp_keyword_found = found_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      result.done |-> load_ok)
      else $error("result loaded while output register full");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      result.done |=> (valid_ff && found_ff == $past(result.found)))
      else $error("loaded result not presented");

   a_idle_stays_empty: assert property (@(posedge clock) disable iff (reset)
      (!result.done && (!valid_ff || rsp_ready)) |=> !valid_ff)
      else $error("result word appeared without a query end");

endmodule

>>> rtl/sql_keyword_scanner_top.sv
// Top level of the SQL keyword scanner: input handshake, scan core and result register.
// The result word for a query is valid in the cycle after its last byte is accepted.
// Throughput: one byte per cycle; a byte is refused only when it ends a query while the
// previous result word is still held and not being taken.
// Reset (synchronous, active high) returns the scanner to normal text with no token open,
// no keyword seen, and an empty result register.
module sql_keyword_scanner_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_char_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_keyword_found
);
   import sks_pkg::*;

   result_type result;
   logic       load_ok;
   logic       step_valid;

   // Bytes inside a query never produce a result word, so they are always taken.
   // Only the closing byte has to wait for room in the result register; the
   // register frees itself in the same cycle that the consumer takes its word,
   // so back-to-back queries keep moving at one byte per cycle while the consumer takes each word.
   assign req_ready  = load_ok || !req_last_byte;
   assign step_valid = req_valid && req_ready;

   // The core holds the scan mode, the open token's length and match bits, and the
   // sticky found flag; each accepted byte updates them.
   sks_scan_core u_core (
      .clock      (clock),
      .reset      (reset),
      .step_valid (step_valid),
      .char_byte  (req_char_byte),
      .last_byte  (req_last_byte),
      .result     (result)
   );

   // The result register holds each query's answer word until the consumer takes it.
   sks_out_reg u_out (
      .clock             (clock),
      .reset             (reset),
      .result            (result),
      .load_ok           (load_ok),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_keyword_found (rsp_keyword_found)
   );

   a_mid_query_ready: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_last_byte) |-> req_ready)
      else $error("byte inside a query was refused");

   a_end_gives_word: assert property (@(posedge clock) disable iff (reset)
      (step_valid && req_last_byte) |=> rsp_valid)
      else $error("query end produced no result word");

   a_held_blocks_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !(step_valid && req_last_byte))
      else $error("query end accepted while result word held");

endmodule

>>> verif/testbench.sv
// Self-checking testbench for the SQL keyword scanner: directed queries, then random ones.
module testbench;
   import sks_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // Cycles without any accepted word on either channel before the run is declared hung.
   // The slowest legal wait is a long sender gap plus a long receiver stall, well under this.
   localparam int STALL_LIMIT = 2000;
   localparam int RAND_BYTES  = 380;
   localparam int RAND_QUERIES = 10;
   localparam int DIR_ROWS    = 16;
   // Cycles allowed after the last expected word for any stray extra word to show up.
   localparam int DRAIN_CYCLES = 8;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_char_byte = 8'h00;
   logic       req_last_byte = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_keyword_found;

   sql_keyword_scanner_top uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_char_byte     (req_char_byte),
      .req_last_byte     (req_last_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_keyword_found (rsp_keyword_found)
   );

   // One byte of the planned stimulus. The hold flag makes the sender wait until every
   // expected answer has been taken before it offers this byte.
   typedef struct packed {
      logic [7:0] ch;
      logic       last;
      logic       hold;
      logic       has_fixed;
      logic       fixed_val;
   } stim_item_type;

   stim_item_type byte_plan [$];
   logic [7:0] query_buf [$];
   bit         pending_found [$];
   int         mismatches = 0;
   bit         quiet = 1'b0;

   // Both spellings of the keyword, upper case.
   logic [7:0] spell_s [0:8] = '{"V", "I", "S", "U", "A", "L", "I", "S", "E"};
   logic [7:0] spell_z [0:8] = '{"V", "I", "S", "U", "A", "L", "I", "Z", "E"};

   // Directed queries. An expected value of -1 means the predictor decides; the rest are
   // simple enough to be stated outright.
   string dir_text [DIR_ROWS] = '{
      "VISUALISE",            // keyword right after reset
      "visualize",            // lower case, Z spelling
      "-- VISUALISE",         // hidden in a line comment
      "-visualise",           // a lone dash is plain text
      "/Visualize",           // a lone slash is plain text
      "/*/ visualise",        // the opening star cannot close the comment
      "/**/visualise",        // empty block comment, then the word
      "'it''s'visualise",     // doubled quote is an escape, next byte confirms the close
      "\"Visua\"\"lise\" x",  // quoted identifier with an escape
      "visualises",           // longer token is not the keyword
      "_visualise",           // underscore joins the token
      "'visualise",           // string left open up to the end
      "--x\nvisualize",       // newline ends the line comment
      "visualis\200e",        // a high byte splits the token
      "\377",                 // largest byte alone
      "VISUALIZE\377"         // largest byte ends the token
   };
   int dir_exp [DIR_ROWS] = '{1, 1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, 0, 1};

   // Predictor state: lexer mode, open token length, surviving spellings, keyword seen.
   mode_type   sc_mode  = MODE_NORMAL;
   logic [3:0] sc_len   = 4'd0;
   logic [1:0] sc_match = MATCH_ALL;
   bit         sc_found = 1'b0;

   function automatic bit word_char(input logic [7:0] c);
      return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
             (c >= "a" && c <= "z") || (c == CH_UNDER);
   endfunction

   // Adds one identifier byte to the open token and drops spellings that no longer fit.
   function automatic void extend_token(input logic [7:0] c);
      logic [7:0] u;
      u = (c >= "a" && c <= "z") ? c - 8'h20 : c;
      if (sc_len < KW_LEN_C) begin
         if (u != spell_s[sc_len]) sc_match[0] = 1'b0;
         if (u != spell_z[sc_len]) sc_match[1] = 1'b0;
      end else begin
         sc_match = 2'b00;
      end
      if (sc_len < LEN_SAT_C) sc_len = sc_len + 4'd1;
   endfunction

   function automatic void close_token();
      if (sc_len == KW_LEN_C && sc_match != 2'b00) sc_found = 1'b1;
      sc_len   = 4'd0;
      sc_match = MATCH_ALL;
   endfunction

   // Handles a byte seen in plain text.
   function automatic void plain_byte(input logic [7:0] c);
      if (word_char(c)) begin
         sc_len   = 4'd0;
         sc_match = MATCH_ALL;
         extend_token(c);
         sc_mode = MODE_IDENT;
      end else if (c == CH_DASH) begin
         sc_mode = MODE_DASH;
      end else if (c == CH_SLASH) begin
         sc_mode = MODE_SLASH;
      end else if (c == CH_SQUOTE) begin
         sc_mode = MODE_SQ;
      end else if (c == CH_DQUOTE) begin
         sc_mode = MODE_DQ;
      end else begin
         sc_mode = MODE_NORMAL;
      end
   endfunction

   // Advances the predicted lexer by one byte. On the last byte of a query it hands back
   // the answer and returns to the reset state.
   function automatic void scan_byte(input logic [7:0] c, input logic last,
                                     output bit got, output bit val);
      got = 1'b0;
      val = 1'b0;
      case (sc_mode)
         MODE_IDENT: begin
            if (word_char(c)) begin
               extend_token(c);
            end else begin
               close_token();
               plain_byte(c);
            end
         end
         MODE_DASH: begin
            if (c == CH_DASH) sc_mode = MODE_LINE;
            else plain_byte(c);
         end
         MODE_SLASH: begin
            if (c == CH_STAR) sc_mode = MODE_BLOCK;
            else plain_byte(c);
         end
         MODE_LINE: begin
            if (c == CH_NEWLINE) sc_mode = MODE_NORMAL;
         end
         MODE_BLOCK: begin
            if (c == CH_STAR) sc_mode = MODE_BSTAR;
         end
         MODE_BSTAR: begin
            if (c == CH_SLASH) sc_mode = MODE_NORMAL;
            else if (c != CH_STAR) sc_mode = MODE_BLOCK;
         end
         MODE_SQ: begin
            if (c == CH_SQUOTE) sc_mode = MODE_SQ_END;
         end
         MODE_SQ_END: begin
            if (c == CH_SQUOTE) sc_mode = MODE_SQ;
            else plain_byte(c);
         end
         MODE_DQ: begin
            if (c == CH_DQUOTE) sc_mode = MODE_DQ_END;
         end
         MODE_DQ_END: begin
            if (c == CH_DQUOTE) sc_mode = MODE_DQ;
            else plain_byte(c);
         end
         default: plain_byte(c);
      endcase
      if (last) begin
         if (sc_mode == MODE_IDENT) close_token();
         got      = 1'b1;
         val      = sc_found;
         sc_mode  = MODE_NORMAL;
         sc_len   = 4'd0;
         sc_match = MATCH_ALL;
         sc_found = 1'b0;
      end
   endfunction

   // Idle length: mostly none, sometimes a few cycles, rarely a long pause.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [7:0] rand_word_char();
      case ($urandom_range(0, 3))
         0: return 8'($urandom_range("A", "Z"));
         1: return 8'($urandom_range("a", "z"));
         2: return 8'($urandom_range("0", "9"));
         default: return CH_UNDER;
      endcase
   endfunction

   function automatic logic [7:0] rand_gap_char();
      case ($urandom_range(0, 5))
         0: return " ";
         1: return ",";
         2: return "(";
         3: return ";";
         4: return 8'h09;
         default: return CH_NEWLINE;
      endcase
   endfunction

   // Appends one byte to the query being built.
   function automatic void add_byte(input logic [7:0] c);
      query_buf.insert(query_buf.size(), c);
   endfunction

   // Appends the keyword in random case and spelling; some copies are spoiled so that
   // near misses are tried as well as hits.
   function automatic void push_keyword();
      logic [7:0] w [$];
      bit zed;
      zed = $urandom_range(0, 1);
      for (int i = 0; i < 9; i++) begin
         w.insert(w.size(),
                  (zed ? spell_z[i] : spell_s[i]) | ($urandom_range(0, 1) ? 8'h20 : 8'h00));
      end
      case ($urandom_range(0, 9))
         0: w.insert(0, rand_word_char());
         1: w.insert(w.size(), rand_word_char());
         2: w.delete($urandom_range(0, 8));
         3: w[$urandom_range(0, 8)] = 8'($urandom_range(0, 255));
         default: ;
      endcase
      foreach (w[i]) add_byte(w[i]);
   endfunction

   // Body of a comment or quoted run: word bytes, delimiters that may close or escape
   // early, the keyword now and then, and any byte at all.
   function automatic void push_content(input int n);
      repeat (n) begin
         case ($urandom_range(0, 10))
            0, 1, 2: add_byte(rand_word_char());
            3: add_byte(CH_STAR);
            4: add_byte(CH_SLASH);
            5: add_byte(CH_SQUOTE);
            6: add_byte(CH_DQUOTE);
            7: add_byte(rand_gap_char());
            8: add_byte(CH_DASH);
            9: push_keyword();
            default: add_byte(8'($urandom_range(0, 255)));
         endcase
      end
   endfunction

   // Builds one random query of a few pieces, mostly well formed, some left open.
   function automatic void build_random_query();
      int pieces;
      query_buf.delete();
      pieces = $urandom_range(1, 5);
      repeat (pieces) begin
         case ($urandom_range(0, 11))
            0, 1, 2: push_keyword();
            3: begin
               repeat ($urandom_range(1, 12)) add_byte(rand_word_char());
            end
            4: add_byte(rand_gap_char());
            5: begin
               add_byte(CH_DASH);
               add_byte(CH_DASH);
               push_content($urandom_range(0, 8));
               if ($urandom_range(0, 4) != 0) add_byte(CH_NEWLINE);
            end
            6: begin
               add_byte(CH_SLASH);
               add_byte(CH_STAR);
               push_content($urandom_range(0, 8));
               if ($urandom_range(0, 4) != 0) begin
                  add_byte(CH_STAR);
                  add_byte(CH_SLASH);
               end
            end
            7: begin
               add_byte(CH_SQUOTE);
               push_content($urandom_range(0, 6));
               if ($urandom_range(0, 4) != 0) add_byte(CH_SQUOTE);
            end
            8: begin
               add_byte(CH_DQUOTE);
               push_content($urandom_range(0, 6));
               if ($urandom_range(0, 4) != 0) add_byte(CH_DQUOTE);
            end
            9: add_byte($urandom_range(0, 1) ? CH_DASH : CH_SLASH);
            default: begin
               repeat ($urandom_range(1, 3)) add_byte(8'($urandom_range(0, 255)));
            end
         endcase
         if ($urandom_range(0, 2) != 0) add_byte(rand_gap_char());
      end
   endfunction

   // Moves the query in query_buf into the plan, marking its final byte.
   function automatic void plan_query(input bit hold, input int fixed_val);
      stim_item_type item;
      foreach (query_buf[i]) begin
         item.ch        = query_buf[i];
         item.last      = (i == query_buf.size() - 1);
         item.hold      = hold && (i == 0);
         item.has_fixed = (fixed_val >= 0);
         item.fixed_val = (fixed_val == 1);
         byte_plan.insert(byte_plan.size(), item);
      end
   endfunction

   initial begin
      forever #1 clock = ~clock;
   end

   // Quiet stretches switch off all idling on both sides for a while. The flag changes
   // on the falling edge so that every reader sees a settled value at the rising edge.
   initial begin
      forever begin
         repeat ($urandom_range(50, 200)) @(negedge clock);
         quiet = ($urandom_range(0, 3) == 0);
      end
   end

   // Sender: builds the whole plan, releases reset, then offers each byte and updates the
   // predictor at the edge where the byte is taken.
   initial begin
      stim_item_type item;
      bit got;
      bit val;
      int gap;
      int rand_bytes;
      int rand_queries;
      bit first;

      for (int r = 0; r < DIR_ROWS; r++) begin
         query_buf.delete();
         for (int i = 0; i < dir_text[r].len(); i++) add_byte(dir_text[r][i]);
         plan_query(1'b0, dir_exp[r]);
      end
      // The smallest byte cannot sit in a string literal, so it gets a query of its own.
      query_buf.delete();
      add_byte(8'h00);
      plan_query(1'b0, 0);

      rand_bytes   = 0;
      rand_queries = 0;
      first        = 1'b1;
      while (rand_bytes < RAND_BYTES || rand_queries < RAND_QUERIES) begin
         build_random_query();
         // The first random query waits for every directed answer; later ones now and then.
         plan_query(first || ($urandom_range(0, 11) == 0), -1);
         first        = 1'b0;
         rand_bytes   += query_buf.size();
         rand_queries += 1;
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (byte_plan[k]) begin
         item = byte_plan[k];
         gap  = pick_gap();
         if (gap > 0 || item.hold) begin
            req_valid <= 1'b0;
            if (item.hold) begin
               // Checked on the falling edge, where the answer queue is stable.
               do @(negedge clock); while (pending_found.size() != 0);
               @(posedge clock);
            end
            repeat (gap) @(posedge clock);
         end
         req_valid     <= 1'b1;
         req_char_byte <= item.ch;
         req_last_byte <= item.last;
         do @(posedge clock); while (!req_ready);
         scan_byte(item.ch, item.last, got, val);
         if (got) pending_found.insert(pending_found.size(), item.has_fixed ? item.fixed_val : val);
      end
      req_valid <= 1'b0;

      do @(negedge clock); while (pending_found.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Receiver: compares each accepted answer word with the oldest expectation and
   // throttles rsp_ready with random stalls.
   initial begin
      int stall;
      bit want;
      stall = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            if (pending_found.size() == 0) begin
               $error("rsp_keyword_found: word with nothing expected, actual %0b",
                      rsp_keyword_found);
               mismatches++;
            end else begin
               want = pending_found.pop_front();
               if (rsp_keyword_found !== want) begin
                  $error("rsp_keyword_found: expected %0b, actual %0b", want, rsp_keyword_found);
                  mismatches++;
               end
            end
         end
         if (stall > 0) begin
            stall--;
            rsp_ready <= 1'b0;
         end else if ($urandom_range(0, 2) == 0) begin
            stall = pick_gap();
            if (stall > 0) stall--;
            rsp_ready <= (stall == 0) && $urandom_range(0, 1);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog: any accepted word on either channel restarts the count.
   initial begin
      int idle;
      idle = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle = 0;
         end else begin
            idle++;
         end
         if (idle >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

endmodule
